### rtl/rnse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnse_pkg: shared types and constants of the nibble stretch encoder
// Byte put request between the sequencer and the word packer, header and
// spread constants, default buffer depth.
// ----------------------------------------------------------------------------
package rnse_pkg;

   localparam int DEF_MAX_STRETCH = 512;
   localparam int CHUNK_LEN       = 255;

   localparam int SYM_W    = 7;
   localparam int BYTE_W   = 8;
   localparam int NIB_W    = 4;
   localparam int WORD_W   = 64;
   localparam int COUNT_W  = 4;
   localparam int LANE_W   = 3;

   localparam logic [BYTE_W-1:0] HEADER_BIT = 8'h80;
   localparam logic [SYM_W-1:0]  MAX_SPREAD = 7'd15;

   // one byte handed to the packer
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
      logic              chunk_end;   // last byte of a chunk, closes the word
      logic              last;        // last byte this item causes
   } put_type;

endpackage

### rtl/range_nibble_stretch_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_nibble_stretch_encoder_unit: frame-of-reference nibble packer
// Gathers symbols into stretches of spread at most 15 and emits each closed
// stretch as chunks of header, length and nibble pairs, packed into words.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid req_stall req_symbol          | in
//           | req_end_of_line                         |
//   rsp     | rsp_valid rsp_stall rsp_out_bytes       | out
//           | rsp_byte_count rsp_last_of_run          |
//
// An item that closes nothing is stored and the unit stays idle. An item
// that closes a stretch walks header, length and data for each chunk, then
// S_START when a spread break starts the next stretch; the buffer walk reads
// one symbol per cycle from the RAM while the walk is not stalled. Stall on
// rsp pauses the walk whenever a word is due and the result register is still
// held. Reset clears the stretch count; the buffer has no clearing pass.
// ----------------------------------------------------------------------------
module range_nibble_stretch_encoder_unit #(
   parameter int MAX_STRETCH = rnse_pkg::DEF_MAX_STRETCH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rnse_pkg::SYM_W-1:0]     req_symbol,
   input  logic                           req_end_of_line,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rnse_pkg::WORD_W-1:0]    rsp_out_bytes,
   output logic [rnse_pkg::COUNT_W-1:0]   rsp_byte_count,
   output logic                           rsp_last_of_run
);
   import rnse_pkg::*;

   localparam int AW = $clog2(MAX_STRETCH);
   localparam int CW = $clog2(MAX_STRETCH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_HDR,
      S_LEN,
      S_DATA
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [SYM_W-1:0]   min_ff, min_in;
   logic [SYM_W-1:0]   max_ff, max_in;
   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic               eol_ff, eol_in;
   logic               restart_ff, restart_in;
   logic               final_ff, final_in;
   logic [CW-1:0]      left_ff, left_in;
   logic [BYTE_W-1:0]  clen_ff, clen_in;
   logic [BYTE_W-1:0]  k_ff, k_in;
   logic [AW-1:0]      rd_addr_ff, rd_addr_in;
   logic [NIB_W-1:0]   hi_ff, hi_in;

   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr;
   logic [SYM_W-1:0]   wr_data, rd_data;
   put_type            put;
   logic               put_ready;

   logic [SYM_W-1:0]   nmin, nmax, spread;
   logic [CW-1:0]      count_inc, left_rem;
   logic [NIB_W-1:0]   nib;
   logic               last_sym, odd_sym;

   // spread check of the incoming symbol
   assign nmin      = (req_symbol < min_ff) ? req_symbol : min_ff;
   assign nmax      = (req_symbol > max_ff) ? req_symbol : max_ff;
   assign spread    = nmax - nmin;
   assign count_inc = count_ff + CW'(1);

   // shared nibble subtract over the buffer walk
   assign nib      = rd_data[NIB_W-1:0] - min_ff[NIB_W-1:0];
   assign odd_sym  = k_ff[0];
   assign last_sym = ({1'b0, k_ff} + 9'd1) == {1'b0, clen_ff};
   assign left_rem = left_ff - CW'(clen_ff);

   assign req_stall = (state_ff != S_IDLE);

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      sym_in     = sym_ff;
      eol_in     = eol_ff;
      restart_in = restart_ff;
      final_in   = final_ff;
      left_in    = left_ff;
      clen_in    = clen_ff;
      k_in       = k_ff;
      rd_addr_in = rd_addr_ff;
      hi_in      = hi_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = sym_ff;
      rd_en      = 1'b0;
      put        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sym_in     = req_symbol;
               eol_in     = req_end_of_line;
               rd_addr_in = '0;
               if (count_ff == '0) begin
                  // empty stretch: open it with this symbol
                  wr_en      = 1'b1;
                  wr_data    = req_symbol;
                  count_in   = CW'(1);
                  min_in     = req_symbol;
                  max_in     = req_symbol;
                  left_in    = CW'(1);
                  final_in   = 1'b1;
                  restart_in = 1'b0;
                  if (req_end_of_line) begin
                     state_in = S_HDR;
                  end
               end else if (spread > MAX_SPREAD) begin
                  // spread break: emit, then restart with this symbol
                  left_in    = count_ff;
                  restart_in = 1'b1;
                  final_in   = !req_end_of_line;
                  state_in   = S_HDR;
               end else begin
                  // append
                  wr_en      = 1'b1;
                  wr_addr    = count_ff[AW-1:0];
                  wr_data    = req_symbol;
                  count_in   = count_inc;
                  min_in     = nmin;
                  max_in     = nmax;
                  left_in    = count_inc;
                  final_in   = 1'b1;
                  restart_in = 1'b0;
                  if (req_end_of_line || count_inc == CW'(MAX_STRETCH)) begin
                     state_in = S_HDR;
                  end
               end
            end
         end
         S_START: begin
            wr_en      = 1'b1;
            count_in   = CW'(1);
            min_in     = sym_ff;
            max_in     = sym_ff;
            left_in    = CW'(1);
            final_in   = 1'b1;
            restart_in = 1'b0;
            rd_addr_in = '0;
            state_in   = eol_ff ? S_HDR : S_IDLE;
         end
         S_HDR: begin
            clen_in   = (left_ff > CW'(CHUNK_LEN)) ? BYTE_W'(CHUNK_LEN)
                                                   : BYTE_W'(left_ff);
            put.valid = 1'b1;
            put.data  = HEADER_BIT | {1'b0, min_ff};
            state_in  = S_LEN;
         end
         S_LEN: begin
            put.valid  = 1'b1;
            put.data   = clen_ff;
            rd_en      = 1'b1;
            rd_addr_in = rd_addr_ff + AW'(1);
            k_in       = '0;
            state_in   = S_DATA;
         end
         S_DATA: begin
            // a byte goes out on every second symbol and on the last one
            put.valid     = odd_sym || last_sym;
            put.data      = odd_sym ? {hi_ff, nib} : {nib, {NIB_W{1'b0}}};
            put.chunk_end = last_sym;
            put.last      = final_ff && last_sym && (left_rem == '0);
            if (!put.valid || put_ready) begin
               if (!odd_sym) begin
                  hi_in = nib;
               end
               k_in = k_ff + BYTE_W'(1);
               if (!last_sym) begin
                  rd_en      = 1'b1;
                  rd_addr_in = rd_addr_ff + AW'(1);
               end else begin
                  left_in = left_rem;
                  if (left_rem != '0) begin
                     state_in = S_HDR;
                  end else begin
                     count_in = '0;
                     state_in = restart_ff ? S_START : S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         min_ff     <= '0;
         max_ff     <= '0;
         restart_ff <= 1'b0;
         final_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         restart_ff <= restart_in;
         final_ff   <= final_in;
      end
      sym_ff     <= sym_in;
      eol_ff     <= eol_in;
      left_ff    <= left_in;
      clen_ff    <= clen_in;
      k_ff       <= k_in;
      rd_addr_ff <= rd_addr_in;
      hi_ff      <= hi_in;
   end

   // stretch buffer
   rnse_ram #(
      .WIDTH (SYM_W),
      .DEPTH (MAX_STRETCH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   // word packer and result register
   rnse_packer u_packer (
      .clock           (clock),
      .reset           (reset),
      .put             (put),
      .put_ready       (put_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_bytes   (rsp_out_bytes),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // an idle stretch never holds a full buffer
   a_count_below_max: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (count_ff < CW'(MAX_STRETCH)))
      else $error("stretch count reached buffer depth while idle");

   // a held stretch keeps its spread within range
   a_spread_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && count_ff != '0) |-> ((max_ff - min_ff) <= MAX_SPREAD))
      else $error("stretch spread exceeds limit");

   // the walk index stays inside the current chunk
   a_walk_in_chunk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DATA) |-> (k_ff < clen_ff && CW'(clen_ff) <= left_ff))
      else $error("buffer walk ran past its chunk");

   // a chunk is never empty
   a_chunk_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LEN) |-> (clen_ff != '0))
      else $error("empty chunk emitted");

endmodule

### rtl/rnse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnse_ram: generic single write, single read RAM
// One write port, one read port with registered read data that holds while
// no read is enabled.
// ----------------------------------------------------------------------------
module rnse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rnse_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnse_packer: byte to word packer with output register
// Collects bytes little-endian into a 64-bit word and hands the word to the
// result register when eight bytes are in or the chunk ends.
// ----------------------------------------------------------------------------
module rnse_packer (
   input  logic                              clock,
   input  logic                              reset,
   input  rnse_pkg::put_type                 put,
   output logic                              put_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rnse_pkg::WORD_W-1:0]       rsp_out_bytes,
   output logic [rnse_pkg::COUNT_W-1:0]      rsp_byte_count,
   output logic                              rsp_last_of_run
);
   import rnse_pkg::*;

   logic [WORD_W-1:0]  acc_ff, acc_in, acc_cur;
   logic [LANE_W-1:0]  len_ff, len_in;
   logic               valid_ff, valid_in;
   logic [WORD_W-1:0]  bytes_ff, bytes_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               last_ff, last_in;
   logic               out_free, do_flush, take;

   // byte lane insert
   assign acc_cur  = acc_ff | (WORD_W'(put.data) << {len_ff, 3'b000});
   assign out_free = !valid_ff || !rsp_stall;
   assign do_flush = put.chunk_end || (len_ff == LANE_W'(7));
   assign put_ready = !do_flush || out_free;
   assign take     = put.valid && put_ready;

   // next word and result register
   always_comb begin
      acc_in   = acc_ff;
      len_in   = len_ff;
      valid_in = valid_ff && rsp_stall;
      bytes_in = bytes_ff;
      count_in = count_ff;
      last_in  = last_ff;
      if (take) begin
         if (do_flush) begin
            acc_in   = '0;
            len_in   = '0;
            valid_in = 1'b1;
            bytes_in = acc_cur;
            count_in = {1'b0, len_ff} + COUNT_W'(1);
            last_in  = put.last;
         end else begin
            acc_in = acc_cur;
            len_in = len_ff + LANE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         len_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         len_ff   <= len_in;
         valid_ff <= valid_in;
      end
      bytes_ff <= bytes_in;
      count_ff <= count_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_bytes   = bytes_ff;
   assign rsp_byte_count  = count_ff;
   assign rsp_last_of_run = last_ff;

endmodule
